FILE: design/websocket_frame_deframer_assert.svh
// Assertion macros for the websocket frame deframer checker
`ifndef WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define WSD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("websocket deframer check failed");

// next-cycle implication, disabled in reset
`define WSD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("websocket deframer check failed");

`endif

FILE: design/wsd_pkg.sv
// Shared types and constants for the websocket frame deframer
`timescale 1ns / 1ps
package wsd_pkg;

   localparam logic [1:0] ST_PAYLOAD = 2'd0;
   localparam logic [1:0] ST_EMPTY   = 2'd1;
   localparam logic [1:0] ST_CLOSE   = 2'd2;

   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;

   localparam logic [1:0] LMODE_SHORT = 2'd0;
   localparam logic [1:0] LMODE_EXT16 = 2'd1;
   localparam logic [1:0] LMODE_EXT64 = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic [3:0] opcode;
      logic [3:0] flags;
      logic [1:0] status;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      req_type data;
   } item_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } result_type;

endpackage

FILE: design/wsd_in_stage.sv
// Input register stage of the websocket frame deframer
`timescale 1ns / 1ps
module wsd_in_stage
   import wsd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  req_type  req_data,
   input  logic     advance,
   output item_type item
);

   logic    valid_ff;
   req_type data_ff;

   assign req_ready = !valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ready) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         data_ff <= req_data;
      end
   end

   assign item.valid = valid_ff;
   assign item.data  = data_ff;

endmodule

FILE: design/wsd_parser.sv
// Frame header parser and payload unmasking for the websocket frame deframer
`timescale 1ns / 1ps
module wsd_parser
   import wsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  item_type   item,
   output result_type res
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_LEN,
      PH_EXT,
      PH_KEY,
      PH_DATA
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  header_count_ff, header_count_in;
   logic [63:0] remaining_length_ff, remaining_length_in;
   logic [31:0] mask_key_ff, mask_key_in;
   logic [1:0]  key_index_ff, key_index_in;
   logic [3:0]  held_opcode_ff, held_opcode_in;
   logic [3:0]  held_flags_ff, held_flags_in;
   logic [1:0]  length_mode_ff, length_mode_in;

   logic       fire;
   logic [7:0] b;
   logic [3:0] count_next;
   logic [3:0] need;
   logic [7:0] key_byte;

   assign fire       = item.valid && advance;
   assign b          = item.data.data_byte;
   assign count_next = header_count_ff + 4'd1;
   assign need       = (length_mode_ff == LMODE_EXT16) ? 4'd2 : 4'd8;

   always_comb begin
      case (key_index_ff)
         2'd0:    key_byte = mask_key_ff[31:24];
         2'd1:    key_byte = mask_key_ff[23:16];
         2'd2:    key_byte = mask_key_ff[15:8];
         default: key_byte = mask_key_ff[7:0];
      endcase
   end

   always_comb begin
      phase_in            = phase_ff;
      header_count_in     = header_count_ff;
      remaining_length_in = remaining_length_ff;
      mask_key_in         = mask_key_ff;
      key_index_in        = key_index_ff;
      held_opcode_in      = held_opcode_ff;
      held_flags_in       = held_flags_ff;
      length_mode_in      = length_mode_ff;

      res.valid             = 1'b0;
      res.data.payload_byte = 8'd0;
      res.data.opcode       = held_opcode_ff;
      res.data.flags        = held_flags_ff;
      res.data.status       = ST_PAYLOAD;
      res.data.last         = 1'b0;

      if (fire) begin
         if (item.data.frame_start) begin
            held_flags_in       = b[7:4];
            held_opcode_in      = b[3:0];
            header_count_in     = 4'd0;
            remaining_length_in = 64'd0;
            mask_key_in         = 32'd0;
            key_index_in        = 2'd0;
            length_mode_in      = LMODE_SHORT;
            phase_in            = PH_LEN;
         end else begin
            case (phase_ff)
               PH_IDLE: begin
                  phase_in = PH_IDLE;
               end
               PH_LEN: begin
                  if (!b[7]) begin
                     phase_in        = PH_IDLE;
                     res.valid       = 1'b1;
                     res.data.status = ST_CLOSE;
                     res.data.last   = 1'b1;
                  end else begin
                     header_count_in = 4'd0;
                     if (b[6:0] == LEN_EXT16) begin
                        length_mode_in      = LMODE_EXT16;
                        remaining_length_in = 64'd0;
                        phase_in            = PH_EXT;
                     end else if (b[6:0] == LEN_EXT64) begin
                        length_mode_in      = LMODE_EXT64;
                        remaining_length_in = 64'd0;
                        phase_in            = PH_EXT;
                     end else begin
                        length_mode_in      = LMODE_SHORT;
                        remaining_length_in = {57'd0, b[6:0]};
                        phase_in            = PH_KEY;
                     end
                  end
               end
               PH_EXT: begin
                  remaining_length_in = {remaining_length_ff[55:0], b};
                  if (count_next >= need) begin
                     header_count_in = 4'd0;
                     phase_in        = PH_KEY;
                  end else begin
                     header_count_in = count_next;
                  end
               end
               PH_KEY: begin
                  mask_key_in = {mask_key_ff[23:0], b};
                  if (count_next >= 4'd4) begin
                     header_count_in = 4'd0;
                     key_index_in    = 2'd0;
                     if (remaining_length_ff == 64'd0) begin
                        phase_in        = PH_IDLE;
                        res.valid       = 1'b1;
                        res.data.status = ST_EMPTY;
                        res.data.last   = 1'b1;
                     end else begin
                        phase_in = PH_DATA;
                     end
                  end else begin
                     header_count_in = count_next;
                  end
               end
               PH_DATA: begin
                  remaining_length_in   = remaining_length_ff - 64'd1;
                  key_index_in          = key_index_ff + 2'd1;
                  res.valid             = 1'b1;
                  res.data.payload_byte = b ^ key_byte;
                  res.data.last         = (remaining_length_ff == 64'd1);
                  if (remaining_length_ff == 64'd1) begin
                     phase_in = PH_IDLE;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff            <= PH_IDLE;
         header_count_ff     <= 4'd0;
         remaining_length_ff <= 64'd0;
         mask_key_ff         <= 32'd0;
         key_index_ff        <= 2'd0;
         held_opcode_ff      <= 4'd0;
         held_flags_ff       <= 4'd0;
         length_mode_ff      <= LMODE_SHORT;
      end else begin
         phase_ff            <= phase_in;
         header_count_ff     <= header_count_in;
         remaining_length_ff <= remaining_length_in;
         mask_key_ff         <= mask_key_in;
         key_index_ff        <= key_index_in;
         held_opcode_ff      <= held_opcode_in;
         held_flags_ff       <= held_flags_in;
         length_mode_ff      <= length_mode_in;
      end
   end

endmodule

FILE: design/wsd_out_stage.sv
// Result register stage of the websocket frame deframer
`timescale 1ns / 1ps
module wsd_out_stage
   import wsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  result_type res,
   output logic       advance,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data
);

   logic    valid_ff;
   rsp_type data_ff;

   assign advance = !valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= res.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res.valid) begin
         data_ff <= res.data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

FILE: design/websocket_frame_deframer.sv
// A byte passes the input register, the combinational parser, then the result register.
// Throughput: one byte per cycle while rsp_ready does not stall the result register.
// Only payload, unmasked length and empty-frame last key bytes give a result; one at most.
// Reset: synchronous, clears the input and result registers and returns the parser to idle.
// Top level of the websocket frame deframer
`timescale 1ns / 1ps
module websocket_frame_deframer
   import wsd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic       advance;
   item_type   item;
   result_type res;

   wsd_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .advance   (advance),
      .item      (item)
   );

   wsd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item),
      .res     (res)
   );

   wsd_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .res       (res),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: design/wsd_checker.sv
// Port-level checker for the websocket frame deframer and its bind
`timescale 1ns / 1ps
`include "websocket_frame_deframer_assert.svh"
module wsd_checker
   import wsd_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   `WSD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `WSD_ASSERT_NOW(a_status_known, rsp_valid, rsp_data.status == ST_PAYLOAD || rsp_data.status == ST_EMPTY || rsp_data.status == ST_CLOSE)
   `WSD_ASSERT_NOW(a_status_only, rsp_valid && rsp_data.status != ST_PAYLOAD, rsp_data.last && rsp_data.payload_byte == 8'd0)
   `WSD_ASSERT_NOW(a_no_stall, rsp_ready, req_ready)

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (.*);
